// ----- design/gjr_pkg.sv -----
// Shared types, constants and helpers for the Gauss-Jordan reduction core.
// Depends on nothing; used by gauss_jordan_rref_rank_core.
`default_nettype none
package gjr_pkg;

    localparam int MAX_DIM    = 8;
    localparam int DIM_W      = 4;
    localparam int IDX_W      = 3;
    localparam int ADDR_W     = 6;
    localparam int DATA_W     = 32;
    localparam int PROD_W     = 64;
    localparam int FRAC_SHIFT = 16;
    localparam int TOL_W      = 8;
    localparam int CFG_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_CNT_W  = 6;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_COUNT   = 2'd0,
        REG_COL_COUNT   = 2'd1,
        REG_ZERO_TOL    = 2'd2,
        REG_OUTPUT_FORM = 2'd3
    } t_cfg_reg;

    // Sequencer states
    typedef enum logic [5:0] {
        S_LOAD,
        S_COLTOP,
        S_SRCH,
        S_SRCH_CHK,
        S_SRCH_END,
        S_SWAP_A,
        S_SWAP_B,
        S_SWAP_C,
        S_SWAP_D,
        S_ELIM_TOP,
        S_ELIM_CHK,
        S_PIV_NEXT,
        S_RED_K,
        S_RED_D,
        S_RED_UTOP,
        S_RED_UCHK,
        S_SC_RD,
        S_SC_MUL,
        S_CLR_START,
        S_CLR_F,
        S_CLR_D,
        S_CLR_RD,
        S_CLR_RX,
        S_CLR_MUL,
        S_DIV_SET,
        S_DIV,
        S_DIV_FIX,
        S_WB,
        S_EMIT_RD,
        S_EMIT_V
    } t_state;

    // Clamp a dimension register into 1..MAX_DIM
    function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] d;
        if (v == '0) begin
            d = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            d = DIM_W'(MAX_DIM);
        end else begin
            d = v;
        end
        return d;
    endfunction

    // Store address of row r, column c
    function automatic logic [ADDR_W-1:0] addr_of(input logic [DIM_W-1:0] r,
                                                  input logic [DIM_W-1:0] c);
        return {r[IDX_W-1:0], c[IDX_W-1:0]};
    endfunction

endpackage
`default_nettype wire

// ----- design/gauss_jordan_rref_rank_core.sv -----
// Gauss-Jordan reduction core: loads a matrix, reduces it, emits it with its rank.
// Depends on gjr_pkg for types, constants and address helpers.
//
//  channel   signals                                   direction
//  input     i_in_valid / o_in_ready, i_element_in     item in
//  output    o_out_valid / i_out_ready, o_element_out,
//            o_is_final, o_rank, o_overflow            item out
//  config    i_cfg_wr_en, i_cfg_index, i_cfg_data      write only
//
// Loading takes one cycle per item; the last item starts the reduction, during
// which no item is accepted. Each elimination update goes through one shared
// multiplier, and every update through a one-bit-per-cycle divider. Results
// then leave one at a time, each read from the store before it is offered.
// Reset is synchronous; it clears the state, load position, rank and overflow flag.
`default_nettype none
module gauss_jordan_rref_rank_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic signed [gjr_pkg::DATA_W-1:0] i_element_in,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic signed [gjr_pkg::DATA_W-1:0]     o_element_out,
    output logic                                  o_is_final,
    output logic [gjr_pkg::DIM_W-1:0]             o_rank,
    output logic                                  o_overflow,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [gjr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [gjr_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int DW = gjr_pkg::DATA_W;
    localparam int PW = gjr_pkg::PROD_W;
    localparam int NW = gjr_pkg::DIM_W;
    localparam int XW = gjr_pkg::IDX_W;
    localparam int AW = gjr_pkg::ADDR_W;
    localparam int TW = PW + 2;
    localparam int DEPTH = gjr_pkg::MAX_DIM * gjr_pkg::MAX_DIM;

    gjr_pkg::t_state r_state, n_state;

    // Configuration
    logic [NW-1:0]              r_row_count, r_col_count;
    logic [gjr_pkg::TOL_W-1:0]  r_tol;
    logic                       r_form;
    logic [NW-1:0]              w_rows, w_cols;

    // Control counters
    logic [NW-1:0] r_lr, r_lc, r_p, r_c, r_r, r_j, r_k, r_u;
    logic [XW-1:0] r_best, r_dst, r_src, r_pc;
    logic [XW-1:0] r_pcol [gjr_pkg::MAX_DIM];
    logic          r_found, r_back, r_scale, r_sat, r_neg;
    logic [gjr_pkg::DIV_CNT_W-1:0] r_cnt;

    // Datapath
    logic signed [DW-1:0] r_mem [DEPTH];
    logic signed [DW-1:0] r_rdata, r_bestv, r_f, r_d, r_x, r_ps;
    logic signed [PW-1:0] r_prod, r_q;
    logic [PW-1:0]        r_num;
    logic [DW-1:0]        r_rem, r_dv;

    logic                 w_we;
    logic [AW-1:0]        w_waddr, w_raddr;
    logic signed [DW-1:0] w_wdata;

    logic                 w_in_acc, w_out_acc, w_load_last, w_emit_last;
    logic                 w_row_end, w_after_red;
    logic [PW-1:0]        w_abs_prod;
    logic [DW-1:0]        w_abs_d;
    logic [DW:0]          w_rem_sh;
    logic [DW+1:0]        w_diff;
    logic                 w_ge;
    logic signed [PW-1:0] w_mul;
    logic signed [TW-1:0] w_t;
    logic signed [DW-1:0] w_clip, w_res;
    logic                 w_sat_hit;
    logic signed [DW:0]   w_tv, w_tol;

    assign w_rows = gjr_pkg::dim_of(r_row_count);
    assign w_cols = gjr_pkg::dim_of(r_col_count);

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_acc   = o_out_valid && i_out_ready;
    assign w_load_last = (r_lr + NW'(1) >= w_rows) && (r_lc + NW'(1) >= w_cols);
    assign w_emit_last = (r_r + NW'(1) >= w_rows) && (r_j + NW'(1) >= w_cols);
    assign w_row_end   = (r_j + NW'(1) >= w_cols);
    assign w_after_red = r_form;

    // Shared multiplier and divider step
    assign w_mul      = r_ps * r_f;
    assign w_abs_prod = r_prod[PW-1] ? PW'(-r_prod) : PW'(r_prod);
    assign w_abs_d    = r_d[DW-1] ? DW'(-r_d) : DW'(r_d);
    assign w_rem_sh   = {r_rem, r_num[PW-1]};
    assign w_diff     = {1'b0, w_rem_sh} - {2'b00, r_dv};
    assign w_ge       = !w_diff[DW+1];

    // Subtract (or pass the quotient when scaling), saturate and snap to zero
    assign w_t = r_scale ? TW'(r_q) : TW'(r_x) - TW'(r_q);
    always_comb begin
        w_sat_hit = 1'b0;
        w_clip    = DW'(w_t);
        if (w_t > TW'(signed'({1'b0, {(DW-1){1'b1}}}))) begin
            w_clip    = {1'b0, {(DW-1){1'b1}}};
            w_sat_hit = 1'b1;
        end else if (w_t < TW'(signed'({1'b1, {(DW-1){1'b0}}}))) begin
            w_clip    = {1'b1, {(DW-1){1'b0}}};
            w_sat_hit = 1'b1;
        end
    end
    assign w_tv  = (DW+1)'(w_clip);
    assign w_tol = $signed({{(DW+1-gjr_pkg::TOL_W){1'b0}}, r_tol});
    assign w_res = ((w_tv < w_tol) && (w_tv > -w_tol)) ? '0 : w_clip;

    // Matrix store
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gjr_pkg::S_LOAD:      if (w_in_acc && w_load_last) n_state = gjr_pkg::S_COLTOP;
            gjr_pkg::S_COLTOP: begin
                if (r_c >= w_cols) begin
                    n_state = w_after_red ? gjr_pkg::S_RED_K : gjr_pkg::S_EMIT_RD;
                end else begin
                    n_state = gjr_pkg::S_SRCH;
                end
            end
            gjr_pkg::S_SRCH:      n_state = gjr_pkg::S_SRCH_CHK;
            gjr_pkg::S_SRCH_CHK: begin
                n_state = (r_r + NW'(1) >= w_rows) ? gjr_pkg::S_SRCH_END : gjr_pkg::S_SRCH;
            end
            gjr_pkg::S_SRCH_END: begin
                if (!r_found) begin
                    n_state = gjr_pkg::S_COLTOP;
                end else if (r_best != r_p[XW-1:0]) begin
                    n_state = gjr_pkg::S_SWAP_A;
                end else begin
                    n_state = gjr_pkg::S_ELIM_TOP;
                end
            end
            gjr_pkg::S_SWAP_A:    n_state = gjr_pkg::S_SWAP_B;
            gjr_pkg::S_SWAP_B:    n_state = gjr_pkg::S_SWAP_C;
            gjr_pkg::S_SWAP_C:    n_state = gjr_pkg::S_SWAP_D;
            gjr_pkg::S_SWAP_D: begin
                n_state = w_row_end ? gjr_pkg::S_ELIM_TOP : gjr_pkg::S_SWAP_A;
            end
            gjr_pkg::S_ELIM_TOP: begin
                n_state = (r_r >= w_rows) ? gjr_pkg::S_PIV_NEXT : gjr_pkg::S_ELIM_CHK;
            end
            gjr_pkg::S_ELIM_CHK: begin
                n_state = (r_rdata != '0) ? gjr_pkg::S_CLR_START : gjr_pkg::S_ELIM_TOP;
            end
            gjr_pkg::S_PIV_NEXT: begin
                if ((r_p + NW'(1) >= w_rows) || (r_p + NW'(1) >= w_cols)) begin
                    n_state = w_after_red ? gjr_pkg::S_RED_K : gjr_pkg::S_EMIT_RD;
                end else begin
                    n_state = gjr_pkg::S_COLTOP;
                end
            end
            gjr_pkg::S_RED_K: begin
                n_state = (r_k >= r_p) ? gjr_pkg::S_EMIT_RD : gjr_pkg::S_RED_D;
            end
            gjr_pkg::S_RED_D: begin
                n_state = (r_rdata == '0) ? gjr_pkg::S_RED_K : gjr_pkg::S_SC_RD;
            end
            gjr_pkg::S_SC_RD:     n_state = gjr_pkg::S_SC_MUL;
            gjr_pkg::S_SC_MUL:    n_state = gjr_pkg::S_DIV_SET;
            gjr_pkg::S_RED_UTOP: begin
                n_state = (r_u >= r_k) ? gjr_pkg::S_RED_K : gjr_pkg::S_RED_UCHK;
            end
            gjr_pkg::S_RED_UCHK: begin
                n_state = (r_rdata != '0) ? gjr_pkg::S_CLR_START : gjr_pkg::S_RED_UTOP;
            end
            gjr_pkg::S_CLR_START: n_state = gjr_pkg::S_CLR_F;
            gjr_pkg::S_CLR_F:     n_state = gjr_pkg::S_CLR_D;
            gjr_pkg::S_CLR_D: begin
                if (r_rdata == '0) begin
                    n_state = r_back ? gjr_pkg::S_RED_UTOP : gjr_pkg::S_ELIM_TOP;
                end else begin
                    n_state = gjr_pkg::S_CLR_RD;
                end
            end
            gjr_pkg::S_CLR_RD:    n_state = gjr_pkg::S_CLR_RX;
            gjr_pkg::S_CLR_RX:    n_state = gjr_pkg::S_CLR_MUL;
            gjr_pkg::S_CLR_MUL:   n_state = gjr_pkg::S_DIV_SET;
            gjr_pkg::S_DIV_SET:   n_state = gjr_pkg::S_DIV;
            gjr_pkg::S_DIV: begin
                if (r_cnt == {gjr_pkg::DIV_CNT_W{1'b1}}) n_state = gjr_pkg::S_DIV_FIX;
            end
            gjr_pkg::S_DIV_FIX:   n_state = gjr_pkg::S_WB;
            gjr_pkg::S_WB: begin
                if (w_row_end) begin
                    if (r_scale || r_back) begin
                        n_state = gjr_pkg::S_RED_UTOP;
                    end else begin
                        n_state = gjr_pkg::S_ELIM_TOP;
                    end
                end else begin
                    n_state = r_scale ? gjr_pkg::S_SC_RD : gjr_pkg::S_CLR_RD;
                end
            end
            gjr_pkg::S_EMIT_RD:   n_state = gjr_pkg::S_EMIT_V;
            gjr_pkg::S_EMIT_V: begin
                // Re-read the store for the next element after each accepted item
                if (w_out_acc) begin
                    n_state = w_emit_last ? gjr_pkg::S_LOAD : gjr_pkg::S_EMIT_RD;
                end
            end
            default:              n_state = gjr_pkg::S_LOAD;
        endcase
    end

    // Outputs, store read and write selection
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        w_we        = 1'b0;
        w_waddr     = gjr_pkg::addr_of(r_lr, r_lc);
        w_wdata     = i_element_in;
        w_raddr     = '0;
        unique case (r_state)
            gjr_pkg::S_LOAD: begin
                o_in_ready = 1'b1;
                w_we       = w_in_acc;
            end
            gjr_pkg::S_SRCH:      w_raddr = gjr_pkg::addr_of(r_r, r_c);
            gjr_pkg::S_SWAP_A:    w_raddr = gjr_pkg::addr_of(r_p, r_j);
            gjr_pkg::S_SWAP_B:    w_raddr = gjr_pkg::addr_of({1'b0, r_best}, r_j);
            gjr_pkg::S_SWAP_C: begin
                w_we    = 1'b1;
                w_waddr = gjr_pkg::addr_of(r_p, r_j);
                w_wdata = r_rdata;
            end
            gjr_pkg::S_SWAP_D: begin
                w_we    = 1'b1;
                w_waddr = gjr_pkg::addr_of({1'b0, r_best}, r_j);
                w_wdata = r_x;
            end
            gjr_pkg::S_ELIM_TOP:  w_raddr = gjr_pkg::addr_of(r_r, r_c);
            gjr_pkg::S_RED_K: begin
                w_raddr = gjr_pkg::addr_of(r_k, {1'b0, r_pcol[r_k[XW-1:0]]});
            end
            gjr_pkg::S_RED_UTOP:  w_raddr = gjr_pkg::addr_of(r_u, {1'b0, r_pc});
            gjr_pkg::S_SC_RD:     w_raddr = gjr_pkg::addr_of({1'b0, r_dst}, r_j);
            gjr_pkg::S_CLR_START: w_raddr = gjr_pkg::addr_of({1'b0, r_dst}, {1'b0, r_pc});
            gjr_pkg::S_CLR_F:     w_raddr = gjr_pkg::addr_of({1'b0, r_src}, {1'b0, r_pc});
            gjr_pkg::S_CLR_RD:    w_raddr = gjr_pkg::addr_of({1'b0, r_src}, r_j);
            gjr_pkg::S_CLR_RX:    w_raddr = gjr_pkg::addr_of({1'b0, r_dst}, r_j);
            gjr_pkg::S_WB: begin
                w_we    = 1'b1;
                w_waddr = gjr_pkg::addr_of({1'b0, r_dst}, r_j);
                w_wdata = w_res;
            end
            gjr_pkg::S_EMIT_RD:   w_raddr = gjr_pkg::addr_of(r_r, r_j);
            gjr_pkg::S_EMIT_V: begin
                w_raddr     = gjr_pkg::addr_of(r_r, r_j);
                o_out_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_element_out = r_rdata;
    assign o_is_final    = w_emit_last;
    assign o_rank        = r_p;
    assign o_overflow    = r_sat;

    // Control registers and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gjr_pkg::S_LOAD;
            r_row_count <= NW'(8);
            r_col_count <= NW'(8);
            r_tol       <= gjr_pkg::TOL_W'(2);
            r_form      <= 1'b1;
            r_lr        <= '0;
            r_lc        <= '0;
            r_p         <= '0;
            r_sat       <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                gjr_pkg::S_LOAD: begin
                    if (w_in_acc) begin
                        if (w_load_last) begin
                            r_lr  <= '0;
                            r_lc  <= '0;
                            r_p   <= '0;
                            r_c   <= '0;
                            r_sat <= 1'b0;
                        end else if (r_lc + NW'(1) >= w_cols) begin
                            r_lc <= '0;
                            r_lr <= r_lr + NW'(1);
                        end else begin
                            r_lc <= r_lc + NW'(1);
                        end
                    end
                end
                gjr_pkg::S_COLTOP: begin
                    if (r_c >= w_cols) begin
                        r_k <= '0;
                        r_r <= '0;
                        r_j <= '0;
                    end else begin
                        r_r     <= r_p;
                        r_found <= 1'b0;
                    end
                end
                gjr_pkg::S_SRCH_CHK: begin
                    if ((r_rdata != '0) && (!r_found || (r_rdata < r_bestv))) begin
                        r_found <= 1'b1;
                        r_best  <= r_r[XW-1:0];
                        r_bestv <= r_rdata;
                    end
                    r_r <= r_r + NW'(1);
                end
                gjr_pkg::S_SRCH_END: begin
                    r_r <= r_p + NW'(1);
                    r_j <= '0;
                    if (!r_found) r_c <= r_c + NW'(1);
                end
                gjr_pkg::S_SWAP_B:    r_x <= r_rdata;
                gjr_pkg::S_SWAP_D:    r_j <= r_j + NW'(1);
                gjr_pkg::S_ELIM_CHK: begin
                    if (r_rdata != '0) begin
                        r_dst   <= r_r[XW-1:0];
                        r_src   <= r_p[XW-1:0];
                        r_pc    <= r_c[XW-1:0];
                        r_back  <= 1'b0;
                        r_scale <= 1'b0;
                    end else begin
                        r_r <= r_r + NW'(1);
                    end
                end
                gjr_pkg::S_PIV_NEXT: begin
                    r_pcol[r_p[XW-1:0]] <= r_c[XW-1:0];
                    r_p <= r_p + NW'(1);
                    r_c <= r_c + NW'(1);
                    r_k <= '0;
                    r_r <= '0;
                    r_j <= '0;
                end
                gjr_pkg::S_RED_K: begin
                    if (r_k >= r_p) begin
                        r_r <= '0;
                        r_j <= '0;
                    end
                end
                gjr_pkg::S_RED_D: begin
                    r_d <= r_rdata;
                    if (r_rdata == '0) begin
                        r_k <= r_k + NW'(1);
                    end else begin
                        r_dst   <= r_k[XW-1:0];
                        r_src   <= r_k[XW-1:0];
                        r_pc    <= r_pcol[r_k[XW-1:0]];
                        r_j     <= {1'b0, r_pcol[r_k[XW-1:0]]};
                        r_scale <= 1'b1;
                    end
                end
                gjr_pkg::S_SC_MUL:    r_prod <= PW'(r_rdata) <<< gjr_pkg::FRAC_SHIFT;
                gjr_pkg::S_RED_UTOP: begin
                    if (r_u >= r_k) r_k <= r_k + NW'(1);
                end
                gjr_pkg::S_RED_UCHK: begin
                    if (r_rdata != '0) begin
                        r_dst   <= r_u[XW-1:0];
                        r_back  <= 1'b1;
                        r_scale <= 1'b0;
                    end else begin
                        r_u <= r_u + NW'(1);
                    end
                end
                gjr_pkg::S_CLR_F:     r_f <= r_rdata;
                gjr_pkg::S_CLR_D: begin
                    r_d <= r_rdata;
                    r_j <= {1'b0, r_pc};
                    if (r_rdata == '0) begin
                        if (r_back) r_u <= r_u + NW'(1);
                        else        r_r <= r_r + NW'(1);
                    end
                end
                gjr_pkg::S_CLR_RX:    r_ps <= r_rdata;
                gjr_pkg::S_CLR_MUL: begin
                    r_x    <= r_rdata;
                    r_prod <= w_mul;
                end
                gjr_pkg::S_DIV_SET: begin
                    r_num <= w_abs_prod;
                    r_dv  <= w_abs_d;
                    r_rem <= '0;
                    r_neg <= r_prod[PW-1] ^ r_d[DW-1];
                    r_cnt <= '0;
                end
                gjr_pkg::S_DIV: begin
                    r_num <= {r_num[PW-2:0], w_ge};
                    r_rem <= w_ge ? w_diff[DW-1:0] : w_rem_sh[DW-1:0];
                    r_cnt <= r_cnt + gjr_pkg::DIV_CNT_W'(1);
                end
                gjr_pkg::S_DIV_FIX:   r_q <= r_neg ? -$signed(r_num) : $signed(r_num);
                gjr_pkg::S_WB: begin
                    if (w_sat_hit) r_sat <= 1'b1;
                    r_j <= r_j + NW'(1);
                    if (w_row_end) begin
                        if (r_scale)     r_u <= '0;
                        else if (r_back) r_u <= r_u + NW'(1);
                        else             r_r <= r_r + NW'(1);
                    end
                end
                gjr_pkg::S_EMIT_V: begin
                    if (w_out_acc) begin
                        if (w_row_end) begin
                            r_j <= '0;
                            r_r <= r_r + NW'(1);
                        end else begin
                            r_j <= r_j + NW'(1);
                        end
                    end
                end
                default: begin
                end
            endcase

            // Register writes; a dimension change resets the load position
            if (i_cfg_wr_en) begin
                unique case (gjr_pkg::t_cfg_reg'(i_cfg_index))
                    gjr_pkg::REG_ROW_COUNT: begin
                        r_row_count <= i_cfg_data[NW-1:0];
                        r_lr        <= '0;
                        r_lc        <= '0;
                    end
                    gjr_pkg::REG_COL_COUNT: begin
                        r_col_count <= i_cfg_data[NW-1:0];
                        r_lr        <= '0;
                        r_lc        <= '0;
                    end
                    gjr_pkg::REG_ZERO_TOL:    r_tol  <= i_cfg_data[gjr_pkg::TOL_W-1:0];
                    gjr_pkg::REG_OUTPUT_FORM: r_form <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule
`default_nettype wire
